// ===== hdl/http_req_pkg.sv =====
package http_req_pkg;

    // parser phases, one-hot
    typedef enum logic [6:0] {
        PH_METHOD  = 7'b0000001,
        PH_PATH    = 7'b0000010,
        PH_VERSION = 7'b0000100,
        PH_NAME    = 7'b0001000,
        PH_SKIP    = 7'b0010000,
        PH_VALUE   = 7'b0100000,
        PH_BODY    = 7'b1000000
    } phase_t;

    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_AUTH = 2'd1,
        KIND_CLEN = 2'd2
    } kind_t;

    // verdicts; the low two bits are the status code
    typedef enum logic [2:0] {
        V_OK   = 3'd0,
        V_MORE = 3'd1,
        V_BAD  = 3'd2,
        V_BIG  = 3'd3,
        V_NONE = 3'd4
    } verdict_t;

    localparam logic [2:0] CLS_OTHER  = 3'd0;
    localparam logic [2:0] CLS_METHOD = 3'd1;
    localparam logic [2:0] CLS_PATH   = 3'd2;
    localparam logic [2:0] CLS_AUTH   = 3'd3;
    localparam logic [2:0] CLS_BODY   = 3'd4;

    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam int REQUEST_MAX_DEF = 4096;
    localparam int METHOD_MAX_DEF  = 16;
    localparam int PATH_MAX_DEF    = 256;
    localparam int AUTH_MAX_DEF    = 256;

    // "HTTP/"
    function automatic logic [7:0] version_char(input logic [3:0] idx);
        logic [7:0] ch;
        unique case (idx)
            4'd0:    ch = 8'h48;
            4'd1:    ch = 8'h54;
            4'd2:    ch = 8'h54;
            4'd3:    ch = 8'h50;
            default: ch = 8'h2f;
        endcase
        return ch;
    endfunction

    // "authorization"
    function automatic logic [7:0] auth_char(input logic [3:0] idx);
        logic [7:0] ch;
        unique case (idx)
            4'd0:    ch = "a";
            4'd1:    ch = "u";
            4'd2:    ch = "t";
            4'd3:    ch = "h";
            4'd4:    ch = "o";
            4'd5:    ch = "r";
            4'd6:    ch = "i";
            4'd7:    ch = "z";
            4'd8:    ch = "a";
            4'd9:    ch = "t";
            4'd10:   ch = "i";
            4'd11:   ch = "o";
            default: ch = "n";
        endcase
        return ch;
    endfunction

    // "content-length"
    function automatic logic [7:0] clen_char(input logic [3:0] idx);
        logic [7:0] ch;
        unique case (idx)
            4'd0:    ch = "c";
            4'd1:    ch = "o";
            4'd2:    ch = "n";
            4'd3:    ch = "t";
            4'd4:    ch = "e";
            4'd5:    ch = "n";
            4'd6:    ch = "t";
            4'd7:    ch = "-";
            4'd8:    ch = "l";
            4'd9:    ch = "e";
            4'd10:   ch = "n";
            4'd11:   ch = "g";
            4'd12:   ch = "t";
            default: ch = "h";
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5a) ? c + 8'h20 : c;
    endfunction

endpackage

// ===== hdl/http_request_header_parser.sv =====
// Streaming HTTP/1.1 request header checker. One request byte is accepted per transaction and
// every byte gives exactly one result transaction, tagging it as method, path, authorization
// value or body byte and echoing it. On the byte that settles the request the result carries the
// verdict (ok, need more, bad, too large) and the collected lengths; after all but need more the
// parser starts over. Throughput is one byte per clock: the whole per-byte update, including a
// held carriage return resolved together with the following byte, sits between the state registers
// and the result register, so s_ready only drops while a result waits.
module http_request_header_parser #(
    parameter int REQUEST_MAX = http_req_pkg::REQUEST_MAX_DEF,
    parameter int METHOD_MAX  = http_req_pkg::METHOD_MAX_DEF,
    parameter int PATH_MAX    = http_req_pkg::PATH_MAX_DEF,
    parameter int AUTH_MAX    = http_req_pkg::AUTH_MAX_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_end_of_data,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_byte_class,
    output logic [7:0]  m_byte_echo,
    output logic        m_verdict_valid,
    output logic [1:0]  m_status,
    output logic [3:0]  m_method_length,
    output logic [7:0]  m_path_length,
    output logic [7:0]  m_auth_length,
    output logic [12:0] m_body_length
);

    localparam int MAX_MP = (METHOD_MAX > PATH_MAX) ? METHOD_MAX : PATH_MAX;
    localparam int MAX_F  = (MAX_MP > AUTH_MAX) ? MAX_MP : AUTH_MAX;
    localparam int FW     = $clog2(MAX_F + 1);
    localparam int LW     = $clog2(REQUEST_MAX + 2);
    localparam int TW     = $clog2(REQUEST_MAX + 1);
    localparam int PW     = LW + 4;

    typedef struct packed {
        http_req_pkg::phase_t phase;
        logic [TW-1:0]        total;
        logic [FW-1:0]        fcount;
        logic [3:0]           nmi;
        http_req_pkg::kind_t  kind;
        logic                 fl_cr;
        logic                 fl_auth;
        logic                 fl_clen;
        logic [LW-1:0]        acc;
        logic [4:0]           digits;
        logic [LW-1:0]        body_rem;
        logic [FW-1:0]        sv_method;
        logic [FW-1:0]        sv_path;
        logic [FW-1:0]        sv_auth;
        logic [LW-1:0]        sv_body;
    } st_t;

    typedef struct packed {
        st_t                    s;
        http_req_pkg::verdict_t v;
        logic [2:0]             cls;
    } res_t;

    localparam st_t ST_RESET = '{
        phase: http_req_pkg::PH_METHOD, kind: http_req_pkg::KIND_NONE, default: '0};

    st_t  state_reg, state_next;
    res_t step;

    logic        m_valid_reg;
    logic [2:0]  cls_reg;
    logic [7:0]  echo_reg;
    logic        vvalid_reg;
    logic [1:0]  status_reg;
    logic [3:0]  mlen_reg;
    logic [7:0]  plen_reg;
    logic [7:0]  alen_reg;
    logic [12:0] blen_reg;

    function automatic st_t start_line(input st_t si);
        st_t s;
        s = si;
        s.phase   = http_req_pkg::PH_NAME;
        s.nmi     = '0;
        s.kind    = http_req_pkg::KIND_NONE;
        s.fl_auth = 1'b1;
        s.fl_clen = 1'b1;
        s.fcount  = '0;
        s.acc     = '0;
        s.digits  = '0;
        return s;
    endfunction

    // value byte of an authorization or content-length line
    function automatic res_t value_byte(input res_t ri, input logic [7:0] c);
        res_t          r;
        logic [PW-1:0] prod;
        r = ri;
        prod = '0;
        if (r.s.kind == http_req_pkg::KIND_AUTH) begin
            if (r.s.fcount < FW'(AUTH_MAX)) r.s.fcount = r.s.fcount + 1'b1;
            r.cls = http_req_pkg::CLS_AUTH;
        end else if (c < http_req_pkg::CH_ZERO || c > http_req_pkg::CH_NINE) begin
            r.v = http_req_pkg::V_BAD;
        end else begin
            r.s.digits = r.s.digits + 1'b1;
            if (r.s.digits > 5'd15) begin
                r.v = http_req_pkg::V_BAD;
            end else begin
                prod = (PW'(r.s.acc) << 3) + (PW'(r.s.acc) << 1) + PW'(c - http_req_pkg::CH_ZERO);
                if (prod > PW'(REQUEST_MAX)) r.s.acc = LW'(REQUEST_MAX + 1);
                else r.s.acc = prod[LW-1:0];
            end
        end
        return r;
    endfunction

    // one ordinary (non line-ending) byte
    function automatic res_t feed(input st_t si, input logic [7:0] c);
        res_t       r;
        logic [7:0] lc;
        r.s   = si;
        r.v   = http_req_pkg::V_NONE;
        r.cls = http_req_pkg::CLS_OTHER;
        lc    = http_req_pkg::to_lower(c);
        unique case (si.phase)
            http_req_pkg::PH_METHOD: begin
                if (c == http_req_pkg::CH_SPACE) begin
                    if (si.fcount == '0) r.v = http_req_pkg::V_BAD;
                    else begin
                        r.s.sv_method = si.fcount;
                        r.s.fcount    = '0;
                        r.s.phase     = http_req_pkg::PH_PATH;
                    end
                end else begin
                    r.s.fcount = si.fcount + 1'b1;
                    r.cls      = http_req_pkg::CLS_METHOD;
                    if (r.s.fcount >= FW'(METHOD_MAX)) r.v = http_req_pkg::V_BAD;
                end
            end
            http_req_pkg::PH_PATH: begin
                if (c == http_req_pkg::CH_SPACE) begin
                    if (si.fcount == '0) r.v = http_req_pkg::V_BAD;
                    else begin
                        r.s.sv_path = si.fcount;
                        r.s.fcount  = '0;
                        r.s.nmi     = '0;
                        r.s.phase   = http_req_pkg::PH_VERSION;
                    end
                end else begin
                    r.s.fcount = si.fcount + 1'b1;
                    r.cls      = http_req_pkg::CLS_PATH;
                    if (r.s.fcount >= FW'(PATH_MAX)) r.v = http_req_pkg::V_BAD;
                end
            end
            http_req_pkg::PH_VERSION: begin
                if (si.nmi < 4'd5) begin
                    if (c != http_req_pkg::version_char(si.nmi)) r.v = http_req_pkg::V_BAD;
                    else r.s.nmi = si.nmi + 1'b1;
                end
            end
            http_req_pkg::PH_NAME: begin
                if (si.kind != http_req_pkg::KIND_NONE) begin
                    if (c == http_req_pkg::CH_COLON) begin
                        r.s.phase  = http_req_pkg::PH_SKIP;
                        r.s.fcount = '0;
                    end
                end else if (si.nmi < 4'd15) begin
                    if (si.nmi < 4'd13 && si.fl_auth && lc != http_req_pkg::auth_char(si.nmi))
                        r.s.fl_auth = 1'b0;
                    if (si.nmi < 4'd14 && si.fl_clen && lc != http_req_pkg::clen_char(si.nmi))
                        r.s.fl_clen = 1'b0;
                    r.s.nmi = si.nmi + 1'b1;
                    if (r.s.nmi == 4'd13 && r.s.fl_auth) r.s.kind = http_req_pkg::KIND_AUTH;
                    if (r.s.nmi == 4'd14 && r.s.fl_clen) r.s.kind = http_req_pkg::KIND_CLEN;
                end
            end
            http_req_pkg::PH_SKIP: begin
                if (c != http_req_pkg::CH_SPACE && c != http_req_pkg::CH_TAB) begin
                    r.s.phase = http_req_pkg::PH_VALUE;
                    r = value_byte(r, c);
                end
            end
            http_req_pkg::PH_VALUE: r = value_byte(r, c);
            default: ;
        endcase
        return r;
    endfunction

    // CR LF pair
    function automatic res_t line_end(input st_t si);
        res_t r;
        r.s   = si;
        r.v   = http_req_pkg::V_NONE;
        r.cls = http_req_pkg::CLS_OTHER;
        if (si.phase == http_req_pkg::PH_METHOD || si.phase == http_req_pkg::PH_PATH) begin
            r.v = http_req_pkg::V_BAD;
        end else if (si.phase == http_req_pkg::PH_VERSION) begin
            if (si.nmi < 4'd5) r.v = http_req_pkg::V_BAD;
            else r.s = start_line(si);
        end else if (si.phase == http_req_pkg::PH_NAME && si.nmi == '0) begin
            // empty line closes the header block
            if (si.sv_body != '0) begin
                r.s.phase    = http_req_pkg::PH_BODY;
                r.s.body_rem = si.sv_body;
                r.s.fl_auth  = 1'b0;
                r.s.fl_clen  = 1'b0;
                r.s.fl_cr    = 1'b0;
            end else begin
                r.v = http_req_pkg::V_OK;
            end
        end else begin
            if (si.kind == http_req_pkg::KIND_AUTH) begin
                if (si.phase == http_req_pkg::PH_VALUE && si.fcount != '0 &&
                    si.fcount < FW'(AUTH_MAX))
                    r.s.sv_auth = si.fcount;
            end else if (si.kind == http_req_pkg::KIND_CLEN) begin
                if (si.phase != http_req_pkg::PH_VALUE) r.v = http_req_pkg::V_BAD;
                else if (si.acc > LW'(REQUEST_MAX)) r.v = http_req_pkg::V_BIG;
                else r.s.sv_body = si.acc;
            end
            if (r.v == http_req_pkg::V_NONE) r.s = start_line(r.s);
        end
        return r;
    endfunction

    // per-byte update
    always_comb begin
        st_t  s;
        res_t r1;
        s = state_reg;
        if (s.total < TW'(REQUEST_MAX)) s.total = s.total + 1'b1;
        step.s   = s;
        step.v   = http_req_pkg::V_NONE;
        step.cls = http_req_pkg::CLS_OTHER;
        r1       = step;
        if (s.phase == http_req_pkg::PH_BODY) begin
            step.cls = http_req_pkg::CLS_BODY;
            if (s.body_rem != '0) step.s.body_rem = s.body_rem - 1'b1;
            if (step.s.body_rem == '0) step.v = http_req_pkg::V_OK;
        end else if (s.fl_cr) begin
            s.fl_cr = 1'b0;
            if (s_data_byte == http_req_pkg::CH_LF) begin
                step = line_end(s);
            end else begin
                // held CR was an ordinary byte after all
                r1 = feed(s, http_req_pkg::CH_CR);
                step.s = r1.s;
                step.v = r1.v;
                if (r1.v == http_req_pkg::V_NONE) begin
                    if (s_data_byte == http_req_pkg::CH_CR) step.s.fl_cr = 1'b1;
                    else step = feed(r1.s, s_data_byte);
                end
            end
        end else if (s_data_byte == http_req_pkg::CH_CR) begin
            step.s.fl_cr = 1'b1;
        end else begin
            step = feed(s, s_data_byte);
        end
        if (step.v == http_req_pkg::V_NONE && s.total >= TW'(REQUEST_MAX))
            step.v = http_req_pkg::V_BIG;
        if (step.v == http_req_pkg::V_NONE && s_end_of_data)
            step.v = http_req_pkg::V_MORE;
    end

    always_comb begin
        state_next = step.s;
        if (step.v == http_req_pkg::V_OK || step.v == http_req_pkg::V_BAD ||
            step.v == http_req_pkg::V_BIG)
            state_next = ST_RESET;
    end

    assign s_ready = !m_valid_reg || m_ready;

    // parser state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                state_reg   <= state_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            cls_reg  <= step.cls;
            echo_reg <= s_data_byte;
            if (step.v == http_req_pkg::V_NONE) begin
                vvalid_reg <= 1'b0;
                status_reg <= '0;
                mlen_reg   <= '0;
                plen_reg   <= '0;
                alen_reg   <= '0;
                blen_reg   <= '0;
            end else begin
                vvalid_reg <= 1'b1;
                status_reg <= step.v[1:0];
                mlen_reg   <= 4'(step.s.sv_method);
                plen_reg   <= 8'(32'(step.s.sv_path));
                alen_reg   <= 8'(32'(step.s.sv_auth));
                blen_reg   <= 13'(32'(step.s.sv_body));
            end
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_byte_class    = cls_reg;
    assign m_byte_echo     = echo_reg;
    assign m_verdict_valid = vvalid_reg;
    assign m_status        = status_reg;
    assign m_method_length = mlen_reg;
    assign m_path_length   = plen_reg;
    assign m_auth_length   = alen_reg;
    assign m_body_length   = blen_reg;

endmodule

// ===== sim/http_request_header_parser_tb.sv =====
module http_request_header_parser_tb;

    localparam int REQ_MAX  = http_req_pkg::REQUEST_MAX_DEF;
    localparam int METH_MAX = http_req_pkg::METHOD_MAX_DEF;
    localparam int PTH_MAX  = http_req_pkg::PATH_MAX_DEF;
    localparam int ATH_MAX  = http_req_pkg::AUTH_MAX_DEF;
    localparam int CYCLE_LIMIT = 1000000;

    typedef struct packed {
        logic [2:0]  byte_class;
        logic [7:0]  byte_echo;
        logic        verdict_valid;
        logic [1:0]  status;
        logic [3:0]  method_length;
        logic [7:0]  path_length;
        logic [7:0]  auth_length;
        logic [12:0] body_length;
    } byte_result_t;

    typedef struct {
        logic [7:0]   data;
        logic         eod;
        logic         chk;
        byte_result_t res;
    } stim_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data_byte = 8'h00;
    logic        s_end_of_data = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [2:0]  m_byte_class;
    logic [7:0]  m_byte_echo;
    logic        m_verdict_valid;
    logic [1:0]  m_status;
    logic [3:0]  m_method_length;
    logic [7:0]  m_path_length;
    logic [7:0]  m_auth_length;
    logic [12:0] m_body_length;

    http_request_header_parser dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_data_byte(s_data_byte), .s_end_of_data(s_end_of_data),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_byte_class(m_byte_class), .m_byte_echo(m_byte_echo),
        .m_verdict_valid(m_verdict_valid), .m_status(m_status),
        .m_method_length(m_method_length), .m_path_length(m_path_length),
        .m_auth_length(m_auth_length), .m_body_length(m_body_length)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // predictor state
    http_req_pkg::phase_t p_phase;
    http_req_pkg::kind_t  p_kind;
    int unsigned p_total, p_field, p_match, p_acc, p_digits, p_body_left;
    bit          p_cr, p_auth_ok, p_clen_ok;
    int unsigned p_meth, p_path, p_auth, p_body;

    byte_result_t expected_results[$];
    stim_row_t    byte_stream[$];
    int  mismatch_count = 0;
    int  results_seen = 0;
    int  verdicts_seen[4];
    int  cycle_count = 0;
    bit  sender_done = 1'b0;
    bit  tail_phase = 1'b0;
    bit  long_hold = 1'b0;

    function automatic void parser_restart();
        p_phase = http_req_pkg::PH_METHOD; p_kind = http_req_pkg::KIND_NONE;
        p_total = 0; p_field = 0; p_match = 0; p_acc = 0; p_digits = 0;
        p_body_left = 0; p_cr = 0; p_auth_ok = 0; p_clen_ok = 0;
        p_meth = 0; p_path = 0; p_auth = 0; p_body = 0;
    endfunction

    function automatic void header_line_start();
        p_phase = http_req_pkg::PH_NAME; p_match = 0; p_kind = http_req_pkg::KIND_NONE;
        p_auth_ok = 1; p_clen_ok = 1; p_field = 0; p_acc = 0; p_digits = 0;
    endfunction

    function automatic string lc_name(input bit auth);
        return auth ? "authorization" : "content-length";
    endfunction

    function automatic http_req_pkg::verdict_t value_char(input logic [7:0] c,
                                                          inout logic [2:0] cls);
        if (p_kind == http_req_pkg::KIND_AUTH) begin
            if (p_field < ATH_MAX) p_field++;
            cls = http_req_pkg::CLS_AUTH;
            return http_req_pkg::V_NONE;
        end
        if (c < http_req_pkg::CH_ZERO || c > http_req_pkg::CH_NINE) return http_req_pkg::V_BAD;
        p_digits++;
        if (p_digits > 15) return http_req_pkg::V_BAD;
        p_acc = p_acc * 10 + (c - http_req_pkg::CH_ZERO);
        if (p_acc > REQ_MAX) p_acc = REQ_MAX + 1;
        return http_req_pkg::V_NONE;
    endfunction

    function automatic http_req_pkg::verdict_t field_char(input logic [7:0] c,
                                                          inout logic [2:0] cls);
        logic [7:0] lc;
        string an, cn, vp;
        an = lc_name(1); cn = lc_name(0); vp = "HTTP/";
        case (p_phase)
            http_req_pkg::PH_METHOD: begin
                if (c == http_req_pkg::CH_SPACE) begin
                    if (p_field == 0) return http_req_pkg::V_BAD;
                    p_meth = p_field; p_field = 0; p_phase = http_req_pkg::PH_PATH;
                    return http_req_pkg::V_NONE;
                end
                p_field++; cls = http_req_pkg::CLS_METHOD;
                return (p_field >= METH_MAX) ? http_req_pkg::V_BAD : http_req_pkg::V_NONE;
            end
            http_req_pkg::PH_PATH: begin
                if (c == http_req_pkg::CH_SPACE) begin
                    if (p_field == 0) return http_req_pkg::V_BAD;
                    p_path = p_field; p_field = 0; p_match = 0;
                    p_phase = http_req_pkg::PH_VERSION;
                    return http_req_pkg::V_NONE;
                end
                p_field++; cls = http_req_pkg::CLS_PATH;
                return (p_field >= PTH_MAX) ? http_req_pkg::V_BAD : http_req_pkg::V_NONE;
            end
            http_req_pkg::PH_VERSION: begin
                if (p_match < 5) begin
                    if (c != vp[p_match]) return http_req_pkg::V_BAD;
                    p_match++;
                end
                return http_req_pkg::V_NONE;
            end
            http_req_pkg::PH_NAME: begin
                if (p_kind != http_req_pkg::KIND_NONE) begin
                    if (c == http_req_pkg::CH_COLON) begin
                        p_phase = http_req_pkg::PH_SKIP; p_field = 0;
                    end
                    return http_req_pkg::V_NONE;
                end
                if (p_match < 15) begin
                    lc = (c >= "A" && c <= "Z") ? c + 8'h20 : c;
                    if (p_match < 13 && p_auth_ok && lc != an[p_match]) p_auth_ok = 0;
                    if (p_match < 14 && p_clen_ok && lc != cn[p_match]) p_clen_ok = 0;
                    p_match++;
                    if (p_match == 13 && p_auth_ok) p_kind = http_req_pkg::KIND_AUTH;
                    if (p_match == 14 && p_clen_ok) p_kind = http_req_pkg::KIND_CLEN;
                end
                return http_req_pkg::V_NONE;
            end
            http_req_pkg::PH_SKIP: begin
                if (c == http_req_pkg::CH_SPACE || c == http_req_pkg::CH_TAB)
                    return http_req_pkg::V_NONE;
                p_phase = http_req_pkg::PH_VALUE;
                return value_char(c, cls);
            end
            http_req_pkg::PH_VALUE: return value_char(c, cls);
            default: return http_req_pkg::V_NONE;
        endcase
    endfunction

    function automatic http_req_pkg::verdict_t line_done();
        if (p_phase == http_req_pkg::PH_METHOD || p_phase == http_req_pkg::PH_PATH)
            return http_req_pkg::V_BAD;
        if (p_phase == http_req_pkg::PH_VERSION) begin
            if (p_match < 5) return http_req_pkg::V_BAD;
            header_line_start();
            return http_req_pkg::V_NONE;
        end
        if (p_phase == http_req_pkg::PH_NAME && p_match == 0) begin
            if (p_body > 0) begin
                p_phase = http_req_pkg::PH_BODY; p_body_left = p_body;
                p_auth_ok = 0; p_clen_ok = 0; p_cr = 0;
                return http_req_pkg::V_NONE;
            end
            return http_req_pkg::V_OK;
        end
        if (p_kind == http_req_pkg::KIND_AUTH) begin
            if (p_phase == http_req_pkg::PH_VALUE && p_field > 0 && p_field < ATH_MAX)
                p_auth = p_field;
        end else if (p_kind == http_req_pkg::KIND_CLEN) begin
            if (p_phase != http_req_pkg::PH_VALUE) return http_req_pkg::V_BAD;
            if (p_acc > REQ_MAX) return http_req_pkg::V_BIG;
            p_body = p_acc;
        end
        header_line_start();
        return http_req_pkg::V_NONE;
    endfunction

    // works out the result of one accepted request byte
    function automatic byte_result_t classify_byte(input logic [7:0] c, input logic eod);
        byte_result_t r;
        logic [2:0] cls, spare;
        http_req_pkg::verdict_t v;
        cls = http_req_pkg::CLS_OTHER; spare = http_req_pkg::CLS_OTHER;
        v = http_req_pkg::V_NONE;
        if (p_total < REQ_MAX) p_total++;
        if (p_phase == http_req_pkg::PH_BODY) begin
            cls = http_req_pkg::CLS_BODY;
            if (p_body_left > 0) p_body_left--;
            if (p_body_left == 0) v = http_req_pkg::V_OK;
        end else if (p_cr) begin
            p_cr = 0;
            if (c == http_req_pkg::CH_LF) v = line_done();
            else begin
                v = field_char(http_req_pkg::CH_CR, spare);
                if (v == http_req_pkg::V_NONE) begin
                    if (c == http_req_pkg::CH_CR) p_cr = 1;
                    else v = field_char(c, cls);
                end
            end
        end else if (c == http_req_pkg::CH_CR) p_cr = 1;
        else v = field_char(c, cls);
        if (v == http_req_pkg::V_NONE && p_total >= REQ_MAX) v = http_req_pkg::V_BIG;
        if (v == http_req_pkg::V_NONE && eod) v = http_req_pkg::V_MORE;
        r = '0;
        r.byte_class = cls;
        r.byte_echo = c;
        if (v != http_req_pkg::V_NONE) begin
            r.verdict_valid = 1'b1;
            r.status = v[1:0];
            r.method_length = p_meth[3:0];
            r.path_length = p_path[7:0];
            r.auth_length = p_auth[7:0];
            r.body_length = p_body[12:0];
        end
        if (v == http_req_pkg::V_OK || v == http_req_pkg::V_BAD || v == http_req_pkg::V_BIG)
            parser_restart();
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at result %0d: %s got %0d expected %0d",
                 results_seen, what, got, want);
        mismatch_count++;
    endtask

    // stimulus builders
    function automatic void push_byte(input logic [7:0] b, input logic eod = 1'b0);
        stim_row_t s;
        s.data = b; s.eod = eod; s.chk = 1'b0; s.res = '0;
        byte_stream.push_back(s);
    endfunction

    function automatic void push_text(input string t);
        for (int i = 0; i < t.len(); i++) push_byte(t[i]);
    endfunction

    function automatic void push_typed(input logic [7:0] b, input logic [2:0] cls,
                                       input logic vv, input logic [1:0] st,
                                       input int ml, input int pl, input int al,
                                       input int bl);
        stim_row_t s;
        s.data = b; s.eod = 1'b0; s.chk = 1'b1;
        s.res = '{cls, b, vv, st, ml[3:0], pl[7:0], al[7:0], bl[12:0]};
        byte_stream.push_back(s);
    endfunction

    function automatic string mixed_case(input string t);
        string o;
        o = t;
        for (int i = 0; i < o.len(); i++)
            if ($urandom_range(0, 1) && o[i] >= "a" && o[i] <= "z") o[i] = o[i] - 8'h20;
        return o;
    endfunction

    function automatic void push_random_request();
        int n, k;
        string t;
        n = $urandom_range(1, 15) > 12 ? $urandom_range(1, 15) : $urandom_range(1, 5);
        for (int i = 0; i < n; i++) push_byte(8'("A" + $urandom_range(0, 25)));
        push_byte(http_req_pkg::CH_SPACE);
        n = ($urandom_range(0, 40) == 0) ? $urandom_range(200, 255) : $urandom_range(1, 10);
        for (int i = 0; i < n; i++) push_byte(8'($urandom_range(33, 126)));
        push_text(" HTTP/1.1\r\n");
        k = 0;
        for (int h = $urandom_range(0, 3); h > 0; h--) begin
            case ($urandom_range(0, 3))
                0: begin
                    push_text(mixed_case("authorization"));
                    push_text($urandom_range(0, 1) ? ": " : ":\t");
                    for (int i = $urandom_range(0, 12); i > 0; i--)
                        push_byte(8'($urandom_range(33, 126)));
                end
                1: begin
                    k = $urandom_range(0, 3) == 0 ? $urandom_range(0, 5000) :
                        $urandom_range(0, 12);
                    push_text(mixed_case("content-length"));
                    push_text(": ");
                    t.itoa(k);
                    push_text(t);
                end
                2: push_text("Host: x");
                default: begin
                    for (int i = $urandom_range(1, 8); i > 0; i--)
                        push_byte(8'($urandom_range(0, 255)));
                end
            endcase
            push_text("\r\n");
        end
        push_text("\r\n");
        if (k > 0 && k <= 40)
            for (int i = 0; i < k; i++) push_byte(8'($urandom_range(0, 255)));
    endfunction

    // directed rows, expected values typed where obvious
    function automatic void build_directed();
        // minimal request with no headers
        push_typed("G", http_req_pkg::CLS_METHOD, 0, 0, 0, 0, 0, 0);
        push_typed(" ", http_req_pkg::CLS_OTHER, 0, 0, 0, 0, 0, 0);
        push_typed("/", http_req_pkg::CLS_PATH, 0, 0, 0, 0, 0, 0);
        push_text(" HTTP/1.1\r\n\r");
        push_typed(http_req_pkg::CH_LF, http_req_pkg::CLS_OTHER, 1,
                   http_req_pkg::V_OK[1:0], 1, 1, 0, 0);
        // empty method is bad at once
        push_typed(http_req_pkg::CH_SPACE, http_req_pkg::CLS_OTHER, 1,
                   http_req_pkg::V_BAD[1:0], 0, 0, 0, 0);
        // need more, then a stray carriage return and extreme bytes
        push_byte(8'hff, 1'b1);
        push_byte(8'h00);
        push_byte(http_req_pkg::CH_CR);
        push_byte("X");
        push_byte(http_req_pkg::CH_CR);
        push_byte(http_req_pkg::CH_CR);
        push_byte(http_req_pkg::CH_LF);
        // bad version prefix
        push_text("P / HTTQ");
        // repeated headers with body
        push_text("POST /a HTTP/1.0\r\nAuthorization:\t ab\r\nauthorization: xyz\r\n");
        push_text("CONTENT-LENGTH: 2\r\nContent-Length: 3\r\n\r\nabc");
        // oversized content length, then an empty one
        push_text("G / HTTP/1\r\ncontent-length:4097\r\n");
        push_text("G / HTTP/1\r\ncontent-length:\r\n");
    endfunction

    // sender
    initial begin
        stim_row_t s;
        byte_result_t r;
        parser_restart();
        build_directed();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        while (byte_stream.size() > 0) begin
            s = byte_stream.pop_front();
            if (!tail_phase && $urandom_range(0, 5) == 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge aclk);
            end
            s_valid <= 1'b1;
            s_data_byte <= s.data;
            s_end_of_data <= s.eod;
            @(posedge aclk iff s_ready);
            r = classify_byte(s.data, s.eod);
            if (s.chk && r != s.res) begin
                $display("table row for byte %0d disagrees with prediction", s.data);
                mismatch_count++;
            end
            expected_results.push_back(r);
            if (byte_stream.size() == 0 && results_seen + expected_results.size() < 1600) begin
                if (results_seen + expected_results.size() > 1300) tail_phase = 1'b1;
                if (results_seen + expected_results.size() > 600 && !long_hold)
                    long_hold = 1'b1;
                if ($urandom_range(0, 5) == 0)
                    for (int i = $urandom_range(1, 30); i > 0; i--)
                        push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
                else push_random_request();
            end
        end
        s_valid <= 1'b0;
        sender_done = 1'b1;
    end

    // receiver with random stalls and one long hold-off
    initial begin
        bit held;
        held = 0;
        @(posedge aresetn);
        forever begin
            if (long_hold && !held) begin
                held = 1;
                m_ready <= 1'b0;
                repeat (200) @(posedge aclk);
            end
            if (!tail_phase && $urandom_range(0, 4) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
        end
    end

    // result checker
    always @(posedge aclk) begin
        byte_result_t want, got;
        if (aresetn && m_valid && m_ready) begin
            got = '{m_byte_class, m_byte_echo, m_verdict_valid, m_status, m_method_length,
                    m_path_length, m_auth_length, m_body_length};
            if (expected_results.size() == 0) begin
                $display("result with no expectation, byte %0d", m_byte_echo);
                mismatch_count++;
            end else begin
                want = expected_results.pop_front();
                if (got.byte_class != want.byte_class)
                    report_mismatch("byte_class", got.byte_class, want.byte_class);
                if (got.byte_echo != want.byte_echo)
                    report_mismatch("byte_echo", got.byte_echo, want.byte_echo);
                if (got.verdict_valid != want.verdict_valid)
                    report_mismatch("verdict_valid", got.verdict_valid, want.verdict_valid);
                if (got.status != want.status)
                    report_mismatch("status", got.status, want.status);
                if (got.method_length != want.method_length)
                    report_mismatch("method_length", got.method_length, want.method_length);
                if (got.path_length != want.path_length)
                    report_mismatch("path_length", got.path_length, want.path_length);
                if (got.auth_length != want.auth_length)
                    report_mismatch("auth_length", got.auth_length, want.auth_length);
                if (got.body_length != want.body_length)
                    report_mismatch("body_length", got.body_length, want.body_length);
                if (want.verdict_valid) verdicts_seen[want.status]++;
            end
            results_seen++;
        end
    end

    // end of run and timeout
    initial begin
        forever begin
            @(posedge aclk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
            if (sender_done && expected_results.size() == 0) begin
                repeat (10) @(posedge aclk);
                $display("%0d bytes checked: %0d ok, %0d need more, %0d bad, %0d too large",
                         results_seen, verdicts_seen[0], verdicts_seen[1],
                         verdicts_seen[2], verdicts_seen[3]);
                if (mismatch_count == 0) begin
                    $display("No mismatches found");
                end else begin
                    $display("Mismatches found");
                end
                $finish;
            end
        end
    end

endmodule
